[src/ghist_pkg.sv]
package ghist_pkg;

  // fixed field widths
  localparam int unsigned VC_W    = 6;
  localparam int unsigned VTX_W   = 5;
  localparam int unsigned DEG_W   = 5;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned TDATA_W = 16;

  // vertex_count after reset
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // per-cycle control of one counter/tally memory
  typedef struct packed {
    logic rd_en;    // read enable
    logic rd_tal;   // read from the tally region
    logic wr_en;    // write enable
    logic wr_tal;   // write to the tally region
    logic clr_cnt;  // drop all per-vertex counters
    logic clr_tal;  // drop all tally entries
  } mem_ctrl_t;

endpackage

[src/ghist_mem.sv]
module ghist_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned DW    = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ghist_pkg::mem_ctrl_t         ctrl_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [DW-1:0]                wr_data_i,
  output logic [DW-1:0]                rd_data_o
);
  import ghist_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned MW = AW + 1;

  // lower half holds per-vertex degrees, upper half the histogram
  logic [DW-1:0]    mem_q [2**MW];
  logic [DW-1:0]    rdata_q;
  logic             rvld_q;
  logic [DEPTH-1:0] cnt_vld_q;
  logic [DEPTH-1:0] tal_vld_q;

  // storage array with registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[{ctrl_i.wr_tal, wr_addr_i}] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[{ctrl_i.rd_tal, rd_addr_i}];
    end
  end

  // entry valid bits, an invalid entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      tal_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (ctrl_i.clr_cnt) begin
        cnt_vld_q <= '0;
      end else if (ctrl_i.wr_en && !ctrl_i.wr_tal) begin
        cnt_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.clr_tal) begin
        tal_vld_q <= '0;
      end else if (ctrl_i.wr_en && ctrl_i.wr_tal) begin
        tal_vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rvld_q <= ctrl_i.rd_tal ? tal_vld_q[rd_addr_i] : cnt_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

[src/ghist_seq.sv]
module ghist_seq #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]   n_eff_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_mode_i,
  input  logic [ghist_pkg::VTX_W-1:0]         in_src_i,
  input  logic [ghist_pkg::VTX_W-1:0]         in_tgt_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_kind_o,
  output logic [ghist_pkg::DEG_W-1:0]         out_degree_o,
  output logic [ghist_pkg::CNT_W-1:0]         out_count_o,
  output logic                                out_last_o,
  output ghist_pkg::mem_ctrl_t                mem_ctrl_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     om_rd_addr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     om_wr_addr_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]   om_wr_data_o,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]   om_rd_data_i,
  output logic [$clog2(MAX_VERTICES)-1:0]     im_rd_addr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]     im_wr_addr_o,
  output logic [$clog2(MAX_VERTICES+1)-1:0]   im_wr_data_o,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]   im_rd_data_i
);
  import ghist_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned TW = $clog2(MAX_VERTICES + 1);
  localparam logic [TW-1:0] DEG_TOP = TW'(MAX_VERTICES - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ARC_WR = 3'd1;
  localparam logic [2:0] ST_TB_TAL = 3'd2;
  localparam logic [2:0] ST_TB_WR  = 3'd3;
  localparam logic [2:0] ST_EM_RD  = 3'd4;
  localparam logic [2:0] ST_EM_LD  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [VW-1:0]    src_q, src_d, tgt_q, tgt_d;
  logic [VW-1:0]    v_q, v_d;
  logic [VW-1:0]    g_q, g_d;
  logic             kind_q, kind_d;
  logic [VW-1:0]    max_out_q, max_out_d, max_in_q, max_in_d;
  logic             ovalid_q, ovalid_d;
  logic             okind_q, okind_d, olast_q, olast_d;
  logic [DEG_W-1:0] odeg_q, odeg_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic [VW-1:0]    dout, din, gmax;
  logic             arc_ok;

  assign dout   = om_rd_data_i[VW-1:0];
  assign din    = im_rd_data_i[VW-1:0];
  assign gmax   = kind_q ? max_in_q : max_out_q;
  assign arc_ok = (VC_W'(in_src_i) < VC_W'(n_eff_i)) && (VC_W'(in_tgt_i) < VC_W'(n_eff_i));

  // sequencer: arc update, histogram build, row emission
  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    tgt_d        = tgt_q;
    v_d          = v_q;
    g_d          = g_q;
    kind_d       = kind_q;
    max_out_d    = max_out_q;
    max_in_d     = max_in_q;
    ovalid_d     = ovalid_q;
    okind_d      = okind_q;
    olast_d      = olast_q;
    odeg_d       = odeg_q;
    ocnt_d       = ocnt_q;
    mem_ctrl_o   = '0;
    om_rd_addr_o = '0;
    om_wr_addr_o = '0;
    om_wr_data_o = '0;
    im_rd_addr_o = '0;
    im_wr_addr_o = '0;
    im_wr_data_o = '0;
    in_ready_o   = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i) begin
            mem_ctrl_o.clr_tal = 1'b1;
            max_out_d = '0;
            max_in_d  = '0;
            v_d       = '0;
            g_d       = '0;
            kind_d    = 1'b0;
            if (n_eff_i == '0) begin
              state_d = ST_EM_RD;
            end else begin
              mem_ctrl_o.rd_en = 1'b1;
              state_d = ST_TB_TAL;
            end
          end else if (arc_ok) begin
            mem_ctrl_o.rd_en = 1'b1;
            om_rd_addr_o = in_src_i[VW-1:0];
            im_rd_addr_o = in_tgt_i[VW-1:0];
            src_d   = in_src_i[VW-1:0];
            tgt_d   = in_tgt_i[VW-1:0];
            state_d = ST_ARC_WR;
          end
        end
      end
      ST_ARC_WR: begin
        // saturating increment of both degrees
        mem_ctrl_o.wr_en = 1'b1;
        om_wr_addr_o = src_q;
        im_wr_addr_o = tgt_q;
        om_wr_data_o = (om_rd_data_i < DEG_TOP) ? om_rd_data_i + 1'b1 : om_rd_data_i;
        im_wr_data_o = (im_rd_data_i < DEG_TOP) ? im_rd_data_i + 1'b1 : im_rd_data_i;
        state_d = ST_IDLE;
      end
      ST_TB_TAL: begin
        // degree of vertex v is here, fetch its histogram bin
        mem_ctrl_o.rd_en  = 1'b1;
        mem_ctrl_o.rd_tal = 1'b1;
        om_rd_addr_o = dout;
        im_rd_addr_o = din;
        src_d = dout;
        tgt_d = din;
        if (dout > max_out_q) begin
          max_out_d = dout;
        end
        if (din > max_in_q) begin
          max_in_d = din;
        end
        state_d = ST_TB_WR;
      end
      ST_TB_WR: begin
        mem_ctrl_o.wr_en  = 1'b1;
        mem_ctrl_o.wr_tal = 1'b1;
        om_wr_addr_o = src_q;
        im_wr_addr_o = tgt_q;
        om_wr_data_o = om_rd_data_i + 1'b1;
        im_wr_data_o = im_rd_data_i + 1'b1;
        if (VC_W'(v_q) + VC_W'(1) < VC_W'(n_eff_i)) begin
          v_d = v_q + 1'b1;
          mem_ctrl_o.rd_en = 1'b1;
          om_rd_addr_o = v_q + 1'b1;
          im_rd_addr_o = v_q + 1'b1;
          state_d = ST_TB_TAL;
        end else begin
          state_d = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        mem_ctrl_o.rd_en  = 1'b1;
        mem_ctrl_o.rd_tal = 1'b1;
        om_rd_addr_o = g_q;
        im_rd_addr_o = g_q;
        state_d = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          okind_d  = kind_q;
          odeg_d   = DEG_W'(g_q);
          ocnt_d   = CNT_W'(kind_q ? im_rd_data_i : om_rd_data_i);
          olast_d  = kind_q && (g_q == max_in_q);
          if (g_q == gmax) begin
            g_d = '0;
            if (kind_q) begin
              mem_ctrl_o.clr_cnt = 1'b1;
              state_d = ST_IDLE;
            end else begin
              kind_d  = 1'b1;
              state_d = ST_EM_RD;
            end
          end else begin
            g_d     = g_q + 1'b1;
            state_d = ST_EM_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ovalid_q  <= 1'b0;
      src_q     <= '0;
      tgt_q     <= '0;
      v_q       <= '0;
      g_q       <= '0;
      kind_q    <= 1'b0;
      max_out_q <= '0;
      max_in_q  <= '0;
    end else begin
      state_q   <= state_d;
      ovalid_q  <= ovalid_d;
      src_q     <= src_d;
      tgt_q     <= tgt_d;
      v_q       <= v_d;
      g_q       <= g_d;
      kind_q    <= kind_d;
      max_out_q <= max_out_d;
      max_in_q  <= max_in_d;
    end
  end

  // output row register
  always_ff @(posedge clk_i) begin
    okind_q <= okind_d;
    olast_q <= olast_d;
    odeg_q  <= odeg_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_valid_o  = ovalid_q;
  assign out_kind_o   = okind_q;
  assign out_degree_o = odeg_q;
  assign out_count_o  = ocnt_q;
  assign out_last_o   = olast_q;

endmodule

[src/graph_degree_histogram.sv]
// Arc transaction: read of both degree memories, then write-back; an arc
// naming a missing vertex is dropped. Finish transaction: one pass over the
// n vertices builds both histograms (n = vertex count), then each row is
// emitted by a bin read and an output load, which waits for the sink; at most
// 64 rows. Reset: vertex_count returns to 32, the maxima clear, and all
// degrees and tallies read as zero at once through entry valid bits; no
// clearing pass is needed.
module graph_degree_histogram #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ghist_pkg::VC_W-1:0]       cfg_wdata_i,    // vertex_count
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ghist_pkg::TDATA_W-1:0]    s_axis_tdata,   // arc_source[4:0], arc_target[9:5]
  input  logic                             s_axis_tuser,   // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ghist_pkg::TDATA_W-1:0]    m_axis_tdata,   // degree[4:0], vertices_with_degree[10:5]
  output logic                             m_axis_tuser,   // table_kind
  output logic                             m_axis_tlast    // last_row
);
  import ghist_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned TW = $clog2(MAX_VERTICES + 1);

  logic [VC_W-1:0]  vc_q;
  logic [TW-1:0]    n_eff;
  mem_ctrl_t        mem_ctrl;
  logic [VW-1:0]    om_rd_addr, om_wr_addr, im_rd_addr, im_wr_addr;
  logic [TW-1:0]    om_wr_data, om_rd_data, im_wr_data, im_rd_data;
  logic [DEG_W-1:0] out_degree;
  logic [CNT_W-1:0] out_count;

  // vertex_count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VC_RESET;
    end else if (cfg_we_i) begin
      vc_q <= cfg_wdata_i;
    end
  end

  // counts above the table size act as the table size
  assign n_eff = (vc_q > VC_W'(MAX_VERTICES)) ? TW'(MAX_VERTICES) : TW'(vc_q);

  ghist_seq #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .n_eff_i      (n_eff),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_src_i     (s_axis_tdata[VTX_W-1:0]),
    .in_tgt_i     (s_axis_tdata[2*VTX_W-1:VTX_W]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_degree_o (out_degree),
    .out_count_o  (out_count),
    .out_last_o   (m_axis_tlast),
    .mem_ctrl_o   (mem_ctrl),
    .om_rd_addr_o (om_rd_addr),
    .om_wr_addr_o (om_wr_addr),
    .om_wr_data_o (om_wr_data),
    .om_rd_data_i (om_rd_data),
    .im_rd_addr_o (im_rd_addr),
    .im_wr_addr_o (im_wr_addr),
    .im_wr_data_o (im_wr_data),
    .im_rd_data_i (im_rd_data)
  );

  // out-degree counters and histogram
  ghist_mem #(
    .DEPTH(MAX_VERTICES),
    .DW   (TW)
  ) u_out_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (om_rd_addr),
    .wr_addr_i (om_wr_addr),
    .wr_data_i (om_wr_data),
    .rd_data_o (om_rd_data)
  );

  // in-degree counters and histogram
  ghist_mem #(
    .DEPTH(MAX_VERTICES),
    .DW   (TW)
  ) u_in_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .rd_addr_i (im_rd_addr),
    .wr_addr_i (im_wr_addr),
    .wr_data_i (im_wr_data),
    .rd_data_o (im_rd_data)
  );

  assign m_axis_tdata = {(TDATA_W - DEG_W - CNT_W)'(0), out_count, out_degree};

endmodule

[src/ghist_chk.sv]
module ghist_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ghist_pkg::TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tuser,
  input logic                          m_axis_tlast
);

  // a stalled row holds its contents
  a_row_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output row changed");

  // a finish transaction always takes the input out of ready
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken right after a finish transaction");

  // only the in-degree table can end the run
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last row flagged on an out-degree row");

  // a bin never counts more vertices than exist, padding stays zero
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:5] <= 6'd32) && (m_axis_tdata[15:11] == 5'd0))
    else $error("histogram bin out of range");

endmodule

bind graph_degree_histogram ghist_chk u_ghist_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
